### rtl/gdad_pkg.sv
// Shared types, constants and calendar functions of the date add unit.
package gdad_pkg;

  localparam int YearBits = 14;
  localparam int MonthBits = 4;
  localparam int DayBits = 5;

  localparam logic [YearBits-1:0] YearMax = 14'd9999;

  // floor(y / 100) == (y * RecipHundred) >> RecipShift for every 14-bit y.
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int RecipShift = 19;
  localparam int ProdBits = YearBits + 13;

  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
  localparam logic [MonthBits-1:0] MonthApr = 4'd4;
  localparam logic [MonthBits-1:0] MonthJun = 4'd6;
  localparam logic [MonthBits-1:0] MonthSep = 4'd9;
  localparam logic [MonthBits-1:0] MonthNov = 4'd11;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;

  localparam logic [DayBits-1:0] DayFirst = 5'd1;
  localparam logic [DayBits-1:0] DayLastDec = 5'd31;

  localparam logic [6:0] LastInCentury = 7'd99;

  // Running date plus the year broken into its century position.
  typedef struct packed {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    logic [6:0]           mod100;
    logic [1:0]           cent;
  } gdad_date_t;

  function automatic logic is_leap(logic [1:0] y_lo, logic [6:0] mod100, logic [1:0] cent);
    is_leap = ((y_lo == 2'd0) && (mod100 != 7'd0)) || ((mod100 == 7'd0) && (cent == 2'd0));
  endfunction

  function automatic logic [DayBits-1:0] month_len(logic [MonthBits-1:0] month, logic leap);
    case (month)
      MonthFeb: begin
        month_len = leap ? 5'd29 : 5'd28;
      end
      MonthApr, MonthJun, MonthSep, MonthNov: begin
        month_len = 5'd30;
      end
      default: begin
        month_len = 5'd31;
      end
    endcase
  endfunction

endpackage

### rtl/gdad_in_if.sv
// Request channel of the date add unit: start date and signed day offset.
interface gdad_in_if #(
  parameter int OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [13:0]            year_in;
  logic [3:0]             month_in;
  logic [4:0]             day_in;
  logic [OFFSET_BITS-1:0] offset_days;

  modport source (output valid, year_in, month_in, day_in, offset_days, input ready);
  modport sink (input valid, year_in, month_in, day_in, offset_days, output ready);
endinterface

### rtl/gdad_out_if.sv
// Result channel of the date add unit: resulting date and range flag.
interface gdad_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic        range_error;

  modport source (output valid, year_out, month_out, day_out, range_error, input ready);
  modport sink (input valid, year_out, month_out, day_out, range_error, output ready);
endinterface

### rtl/gdad_step.sv
// One-day step of a date, forward or back, with the year range limit.
module gdad_step (
  input  gdad_pkg::gdad_date_t cur,
  input  logic                 back,
  output gdad_pkg::gdad_date_t nxt,
  output logic                 at_limit
);
  import gdad_pkg::*;

  logic                 leap;
  logic [DayBits-1:0]   len_cur;
  logic [DayBits-1:0]   len_prev;
  logic [MonthBits-1:0] month_prev;

  assign leap       = is_leap(cur.year[1:0], cur.mod100, cur.cent);
  assign len_cur    = month_len(cur.month, leap);
  assign month_prev = cur.month - 4'd1;
  assign len_prev   = month_len(month_prev, leap);

  always_comb begin
    nxt      = cur;
    at_limit = 1'b0;
    if (!back) begin
      if (cur.day < len_cur) begin
        nxt.day = cur.day + 5'd1;
      end else if (cur.month < MonthDec) begin
        nxt.month = cur.month + 4'd1;
        nxt.day   = DayFirst;
      end else if (cur.year == YearMax) begin
        at_limit = 1'b1;
      end else begin
        nxt.year  = cur.year + 14'd1;
        nxt.month = MonthJan;
        nxt.day   = DayFirst;
        if (cur.mod100 == LastInCentury) begin
          nxt.mod100 = 7'd0;
          nxt.cent   = cur.cent + 2'd1;
        end else begin
          nxt.mod100 = cur.mod100 + 7'd1;
        end
      end
    end else begin
      if (cur.day > DayFirst) begin
        nxt.day = cur.day - 5'd1;
      end else if (cur.month > MonthJan) begin
        nxt.month = month_prev;
        nxt.day   = len_prev;
      end else if (cur.year == 14'd0) begin
        at_limit = 1'b1;
      end else begin
        nxt.year  = cur.year - 14'd1;
        nxt.month = MonthDec;
        nxt.day   = DayLastDec;
        if (cur.mod100 == 7'd0) begin
          nxt.mod100 = LastInCentury;
          nxt.cent   = cur.cent - 2'd1;
        end else begin
          nxt.mod100 = cur.mod100 - 7'd1;
        end
      end
    end
  end

endmodule

### rtl/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date add unit: sequencer around the day stepper.
// Order: MUL, SPLIT, CHECK, then STEP until the offset is used up or a result
//   clamps at 0000-01-01 or 9999-12-31; an invalid date goes from CHECK to OUT.
// Throughput: one request at a time; the single day stepper advances one day
//   per cycle, so time grows with the offset, at most 2^(OFFSET_BITS-1) days.
// A new request is taken the cycle after the result has been taken.
// Reset (synchronous, active low) returns the sequencer to idle with no result.
module gregorian_date_add_days_unit #(
  parameter int OFFSET_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  gdad_in_if.sink   in_ch,
  gdad_out_if.source out_ch
);
  import gdad_pkg::*;

  // Sequencer: IDLE takes a request, MUL and SPLIT find the year's position
  // in its century and 400-year cycle, CHECK validates the date, STEP walks
  // one day per cycle, and OUT holds the result until it is taken.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_CHECK,
    ST_STEP,
    ST_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  gdad_date_t             date_r, date_nxt;
  logic [OFFSET_BITS-1:0] rem_r, rem_nxt;
  logic                   back_r, back_nxt;
  logic                   err_r, err_nxt;
  logic [ProdBits-1:0]    prod_r, prod_nxt;

  gdad_date_t             step_date;
  logic                   step_limit;

  // Century split of the year by reciprocal multiplication.
  logic [7:0]             century;
  logic [14:0]            century_x100;
  logic [14:0]            year_rem;

  // Date check against the month length of the start year.
  logic                   leap_now;
  logic                   date_bad;

  gdad_step u_step (
    .cur      (date_r),
    .back     (back_r),
    .nxt      (step_date),
    .at_limit (step_limit)
  );

  assign century      = prod_r[RecipShift +: 8];
  assign century_x100 = 15'(century) * 15'd100;
  assign year_rem     = 15'(date_r.year) - century_x100;

  assign leap_now = is_leap(date_r.year[1:0], date_r.mod100, date_r.cent);
  assign date_bad = (date_r.year > YearMax) || (date_r.month < MonthJan) ||
                    (date_r.month > MonthDec) || (date_r.day < DayFirst) ||
                    (date_r.day > month_len(date_r.month, leap_now));

  always_comb begin
    state_nxt = state_r;
    date_nxt  = date_r;
    rem_nxt   = rem_r;
    back_nxt  = back_r;
    err_nxt   = err_r;
    prod_nxt  = prod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          date_nxt.year  = in_ch.year_in;
          date_nxt.month = in_ch.month_in;
          date_nxt.day   = in_ch.day_in;
          back_nxt       = in_ch.offset_days[OFFSET_BITS-1];
          // Keep the magnitude; the most negative offset fits unsigned.
          rem_nxt        = in_ch.offset_days[OFFSET_BITS-1] ?
                           (~in_ch.offset_days + 1'b1) : in_ch.offset_days;
          err_nxt        = 1'b0;
          state_nxt      = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = ProdBits'(date_r.year) * ProdBits'(RecipHundred);
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        date_nxt.mod100 = year_rem[6:0];
        date_nxt.cent   = century[1:0];
        state_nxt       = ST_CHECK;
      end
      ST_CHECK: begin
        if (date_bad) begin
          // Invalid dates are echoed as received, flagged.
          err_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else if (rem_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_limit) begin
          // Date sits on the range boundary and cannot move further.
          err_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          date_nxt = step_date;
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == OFFSET_BITS'(1)) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    date_r <= date_nxt;
    rem_r  <= rem_nxt;
    back_r <= back_nxt;
    err_r  <= err_nxt;
    prod_r <= prod_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.year_out    = date_r.year;
  assign out_ch.month_out   = date_r.month;
  assign out_ch.day_out     = date_r.day;
  assign out_ch.range_error = err_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_MUL)
    else $error("accepted request did not start the sequence");

  a_step_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> date_r.year <= YearMax && date_r.mod100 <= LastInCentury)
    else $error("stepping date left the year range");

  a_good_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.range_error |->
      out_ch.month_out >= MonthJan && out_ch.month_out <= MonthDec &&
      out_ch.day_out >= DayFirst)
    else $error("unflagged result is not a calendar date");

  a_step_progress: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP && !step_limit |=> rem_r == $past(rem_r) - 1'b1)
    else $error("day count did not advance");
`endif

endmodule

### tb/tb_gregorian_date_add_days_unit.sv
// Self-checking testbench of the Gregorian date add unit with its own calendar predictor.
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_unit;
  import gdad_pkg::*;

  localparam int OffsetBits = 16;
  localparam int NumDirected = 24;
  localparam int ReportLimit = 10;
  // Idle wait after the last result has come back, so that a late or extra result is still seen.
  localparam int SettleCycles = 40;
  localparam longint DaysPerCycle = 146097;
  localparam longint YearsPerCycle = 400;

  // One result as it leaves the block.
  typedef struct packed {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    logic                 range_error;
  } date_result_t;

  // One request. A directed row may carry a hand-written expected date in want.
  typedef struct packed {
    logic [YearBits-1:0]          year;
    logic [MonthBits-1:0]         month;
    logic [DayBits-1:0]           day;
    logic signed [OffsetBits-1:0] offset;
    logic                         has_fixed;
    date_result_t                 want;
  } date_request_t;

  localparam date_result_t NoFixed = '0;

  logic clk = 1'b0;
  logic rst_n;

  gdad_in_if #(.OFFSET_BITS(OffsetBits)) req_ch ();
  gdad_out_if res_ch ();

  gregorian_date_add_days_unit #(
    .OFFSET_BITS(OffsetBits)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(res_ch)
  );

  // Dates that accepted requests must produce, oldest first.
  date_result_t pending_dates [$];
  int mismatch_count = 0;
  // Percent of cycles in which the request side and the result side hold off.
  int tx_idle_pct = 21;
  int rx_idle_pct = 50;
  date_request_t directed_rows [0:NumDirected-1];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor. A date is turned into a day count from 0000-01-01, the
  // offset is added, the count is clamped to years 0..9999 and turned back into
  // a date. That gives the same answer as stepping one day at a time.
  // ---------------------------------------------------------------------------

  // Full Gregorian leap rule; year 0 counts as a leap year.
  function automatic bit leap_year(longint yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic longint days_in_month(longint yr, longint mon);
    case (mon)
      longint'(MonthFeb): begin
        return leap_year(yr) ? 29 : 28;
      end
      longint'(MonthApr), longint'(MonthJun), longint'(MonthSep), longint'(MonthNov): begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Days from 0000-01-01 to January 1 of the given year.
  function automatic longint days_to_jan1(longint yr);
    return 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
  endfunction

  function automatic date_result_t shifted_date(date_request_t rq);
    longint yr;
    longint mon;
    longint count;
    longint last_day;
    date_result_t res;
    yr = longint'(rq.year);
    mon = longint'(rq.month);
    res.range_error = 1'b0;
    // An impossible start date comes back unchanged with the error flag.
    if (rq.year > YearMax || mon < 1 || mon > 12 || rq.day < 1 ||
        longint'(rq.day) > days_in_month(yr, mon)) begin
      res.year = rq.year;
      res.month = rq.month;
      res.day = rq.day;
      res.range_error = 1'b1;
      return res;
    end
    count = days_to_jan1(yr);
    for (longint m = 1; m < mon; m++) begin
      count += days_in_month(yr, m);
    end
    count += longint'(rq.day) - 1 + longint'(rq.offset);
    // Results outside the year range stop at the first or the last day.
    last_day = days_to_jan1(longint'(YearMax) + 1) - 1;
    if (count < 0) begin
      count = 0;
      res.range_error = 1'b1;
    end else if (count > last_day) begin
      count = last_day;
      res.range_error = 1'b1;
    end
    // Estimate the year from the 400-year cycle, then correct it.
    yr = count * YearsPerCycle / DaysPerCycle;
    while (yr > 0 && days_to_jan1(yr) > count) begin
      yr--;
    end
    while (yr < longint'(YearMax) && days_to_jan1(yr + 1) <= count) begin
      yr++;
    end
    count -= days_to_jan1(yr);
    mon = 1;
    while (mon < 12 && count >= days_in_month(yr, mon)) begin
      count -= days_in_month(yr, mon);
      mon++;
    end
    res.year = YearBits'(yr);
    res.month = MonthBits'(mon);
    res.day = DayBits'(count + 1);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Every request may be preceded by random idle cycles; valid
  // stays high from one request to the next when no idle cycle falls between.
  // The expected date is queued at the edge where the request is accepted.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input date_request_t rq, input date_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.year_in <= rq.year;
    req_ch.month_in <= rq.month;
    req_ch.day_in <= rq.day;
    req_ch.offset_days <= rq.offset;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    pending_dates.push_back(want);
  endtask

  // Random request. Most start dates are valid and most offsets are short, so
  // that the day stepper finishes quickly; a few offsets span the whole range
  // and some start years sit at either end of the calendar to reach the clamps.
  // The rest are raw field values, mostly impossible dates.
  task automatic random_request();
    date_request_t rq;
    int unsigned mag;
    int unsigned pick;
    rq = '0;
    pick = $urandom_range(99);
    if (pick < 12) begin
      rq.year = YearBits'($urandom_range(16383));
      rq.month = MonthBits'($urandom_range(15));
      rq.day = DayBits'($urandom_range(31));
    end else begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        rq.year = YearBits'($urandom_range(2));
      end else if (pick < 24) begin
        rq.year = YearBits'($urandom_range(9999, 9997));
      end else begin
        rq.year = YearBits'($urandom_range(9999));
      end
      rq.month = MonthBits'($urandom_range(12, 1));
      rq.day = DayBits'($urandom_range(32'(days_in_month(rq.year, rq.month)), 1));
    end
    pick = $urandom_range(99);
    if (pick < 94) begin
      mag = (pick < 72) ? $urandom_range(400) : $urandom_range(4000);
      rq.offset = OffsetBits'(mag);
      if ($urandom_range(1) == 1) begin
        rq.offset = -rq.offset;
      end
    end else begin
      rq.offset = OffsetBits'($urandom());
    end
    issue_request(rq, shifted_date(rq));
  endtask

  // Holds the request side still until every queued date has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic log_mismatch(input string what, input date_result_t want,
                              input date_result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t ns: %s: expected %0d-%0d-%0d err %0b, got %0d-%0d-%0d err %0b",
               $realtime, what, want.year, want.month, want.day, want.range_error,
               got.year, got.month, got.day, got.range_error);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Results are sampled at the rising edge; ready for the next
  // cycle is drawn from the current idle percentage.
  // ---------------------------------------------------------------------------
  initial begin
    date_result_t got;
    date_result_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        got = '{res_ch.year_out, res_ch.month_out, res_ch.day_out, res_ch.range_error};
        if (pending_dates.size() == 0) begin
          log_mismatch("result with no request pending", NoFixed, got);
        end else begin
          want = pending_dates.pop_front();
          if (got !== want) begin
            log_mismatch("date mismatch", want, got);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: far beyond the slowest correct run, even with every offset at full size.
  initial begin
    #200_000_000;
    $display("gregorian_date_add_days_unit verification failed");
    $finish;
  end

  // Directed rows: first the cases whose answer is plain at a glance, then the
  // calendar corners that are left to the predictor.
  initial begin
    directed_rows = '{
      // Zero offset returns the start date.
      '{14'd2000, 4'd1, 5'd1, 16'sh0000, 1'b1, '{14'd2000, 4'd1, 5'd1, 1'b0}},
      // Stepping back from the first day clamps there.
      '{14'd0, 4'd1, 5'd1, 16'shFFFF, 1'b1, '{14'd0, 4'd1, 5'd1, 1'b1}},
      // Stepping past the last day, or back from the first day, clamps there.
      '{14'd9999, 4'd12, 5'd31, 16'sh0001, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
      '{14'd9999, 4'd12, 5'd31, 16'sh7FFF, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
      '{14'd0, 4'd1, 5'd1, 16'sh8000, 1'b1, '{14'd0, 4'd1, 5'd1, 1'b1}},
      // Impossible start dates are echoed with the error flag.
      '{14'd2023, 4'd2, 5'd29, 16'sh0005, 1'b1, '{14'd2023, 4'd2, 5'd29, 1'b1}},
      '{14'd16383, 4'd15, 5'd31, 16'shFFFF, 1'b1, '{14'd16383, 4'd15, 5'd31, 1'b1}},
      '{14'd2024, 4'd0, 5'd0, 16'sh0001, 1'b1, '{14'd2024, 4'd0, 5'd0, 1'b1}},
      '{14'd2024, 4'd13, 5'd10, 16'sh0001, 1'b1, '{14'd2024, 4'd13, 5'd10, 1'b1}},
      '{14'd2024, 4'd4, 5'd31, 16'sh0001, 1'b1, '{14'd2024, 4'd4, 5'd31, 1'b1}},
      // Leap day, century rule, 400-year rule, year rollover, backward over February.
      '{14'd2024, 4'd2, 5'd29, 16'sh0001, 1'b0, NoFixed},
      '{14'd1900, 4'd2, 5'd28, 16'sh0001, 1'b0, NoFixed},
      '{14'd2000, 4'd2, 5'd28, 16'sh0001, 1'b0, NoFixed},
      '{14'd1999, 4'd12, 5'd31, 16'sh0001, 1'b0, NoFixed},
      '{14'd2000, 4'd3, 5'd1, 16'shFFFF, 1'b0, NoFixed},
      // Full-size offsets both ways.
      '{14'd5000, 4'd6, 5'd15, 16'sh7FFF, 1'b0, NoFixed},
      '{14'd5000, 4'd6, 5'd15, 16'sh8000, 1'b0, NoFixed},
      // Landing exactly on the first day of year 0, which is a leap year.
      '{14'd0, 4'd3, 5'd1, 16'shFFC4, 1'b0, NoFixed},
      // Landing exactly on the last day, and one past it.
      '{14'd9999, 4'd12, 5'd1, 16'sh001E, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
      '{14'd9999, 4'd12, 5'd1, 16'sh001F, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
      '{14'd2024, 4'd1, 5'd31, 16'sh001D, 1'b0, NoFixed},
      '{14'd1, 4'd1, 5'd1, 16'shFE92, 1'b0, NoFixed},
      '{14'd2100, 4'd2, 5'd28, 16'sh0001, 1'b0, NoFixed},
      '{14'd1600, 4'd2, 5'd29, 16'sh0010, 1'b0, NoFixed}
    };
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, then three random phases with the
  // idle pattern swapped and finally switched off. The request side is held
  // back between phases until every result is in.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.year_in <= '0;
    req_ch.month_in <= '0;
    req_ch.day_in <= '0;
    req_ch.offset_days <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      issue_request(directed_rows[i], directed_rows[i].has_fixed ? directed_rows[i].want
                                                                 : shifted_date(directed_rows[i]));
    end
    repeat (25) random_request();
    hold_until_drained();

    tx_idle_pct = 50;
    rx_idle_pct = 21;
    repeat (25) random_request();
    hold_until_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (26) random_request();
    hold_until_drained();

    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("gregorian_date_add_days_unit verification clean");
    end else begin
      $display("gregorian_date_add_days_unit verification failed");
    end
    $finish;
  end

endmodule
